// ===== src/triangle_pixel_coverage_shader_top_macros.svh =====
// ---------------------------------------------------------------------------
// triangle pixel coverage shader assertion macros
// concurrent assertion wrappers, clocked on clock, disabled during reset
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_PIXEL_COVERAGE_SHADER_TOP_MACROS_SVH
`define TRIANGLE_PIXEL_COVERAGE_SHADER_TOP_MACROS_SVH

// same-cycle implication
`define TPCS_ASSERT_IMPL(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> post) \
      else $error("assertion failed");

// next-cycle implication
`define TPCS_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> post) \
      else $error("assertion failed");

`endif

// ===== src/tpcs_pkg.sv =====
// ---------------------------------------------------------------------------
// tpcs_pkg
// widths, weights, register indexes and pipeline word types of the shader
// ---------------------------------------------------------------------------
package tpcs_pkg;

   localparam int COORD_BITS   = 10;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS    = 2 * DIFF_BITS;
   localparam int CONST_BITS   = 2 * COORD_BITS;
   localparam int AREA_BITS    = 2 * COORD_BITS + 4;
   localparam int MAG_BITS     = AREA_BITS - 1;
   localparam int GRAY_BITS    = 8;
   localparam int NUM_BITS     = MAG_BITS + GRAY_BITS;
   localparam int DIV_STEPS    = GRAY_BITS;
   localparam int FRONT_STAGES = 3;
   localparam int LATENCY      = FRONT_STAGES + DIV_STEPS;

   localparam int W_A = 23;
   localparam int W_B = 59;
   localparam int W_G = 255;

   localparam int ADDR_BITS    = 5;
   localparam int REG_IDX_BITS = 3;
   localparam int DATA_BITS    = 32;

   localparam logic [REG_IDX_BITS-1:0] REG_VERTEX_A_X = REG_IDX_BITS'(0);
   localparam logic [REG_IDX_BITS-1:0] REG_VERTEX_A_Y = REG_IDX_BITS'(1);
   localparam logic [REG_IDX_BITS-1:0] REG_VERTEX_B_X = REG_IDX_BITS'(2);
   localparam logic [REG_IDX_BITS-1:0] REG_VERTEX_B_Y = REG_IDX_BITS'(3);
   localparam logic [REG_IDX_BITS-1:0] REG_VERTEX_C_X = REG_IDX_BITS'(4);
   localparam logic [REG_IDX_BITS-1:0] REG_VERTEX_C_Y = REG_IDX_BITS'(5);

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by;
      coord_type cx;
      coord_type cy;
   } vertex_set_type;

   // one word moving down the divider chain
   typedef struct packed {
      coord_type              x;
      coord_type              y;
      logic                   covered;
      logic                   degenerate;
      logic [NUM_BITS-1:0]    rem;
      logic [NUM_BITS-1:0]    dsh;
      logic [GRAY_BITS-1:0]   quo;
   } div_word_type;

endpackage

// ===== src/triangle_pixel_coverage_shader_top.sv =====
// ---------------------------------------------------------------------------
// triangle pixel coverage shader
// pixel coverage test and weighted gray level for a triangle held in registers
// ---------------------------------------------------------------------------
// One pixel word is taken in every clock cycle (busy stays low) and its result
// word appears on the rsp_ ports, marked by rsp_valid for one cycle, after it
// passes the edge area arithmetic and then a chain of eight divider cells, one
// quotient bit per cell. The receiver cannot stall, so every rsp_valid cycle
// must be taken. Vertices must be written through the APB port only while no
// pixel is in flight; the block itself does not enforce this. Gray is zero for
// pixels not covered and degenerate flags a zero-area triangle.
`include "triangle_pixel_coverage_shader_top_macros.svh"

module triangle_pixel_coverage_shader_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  tpcs_pkg::coord_type              req_pixel_x,
   input  tpcs_pkg::coord_type              req_pixel_y,
   output logic                             rsp_valid,
   output tpcs_pkg::coord_type              rsp_out_x,
   output tpcs_pkg::coord_type              rsp_out_y,
   output logic                             rsp_covered,
   output logic [tpcs_pkg::GRAY_BITS-1:0]   rsp_gray,
   output logic                             rsp_degenerate,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tpcs_pkg::ADDR_BITS-1:0]   paddr,
   input  logic [tpcs_pkg::DATA_BITS-1:0]   pwdata,
   output logic [tpcs_pkg::DATA_BITS-1:0]   prdata,
   output logic                             pready
);

   localparam int CB = tpcs_pkg::COORD_BITS;

   // configuration registers
   tpcs_pkg::vertex_set_type             vertices_ff;
   tpcs_pkg::vertex_set_type             vertices_in;
   logic [tpcs_pkg::REG_IDX_BITS-1:0]    reg_idx;
   logic                                 wr_en;
   tpcs_pkg::coord_type                  wr_val;
   tpcs_pkg::coord_type                  rd_val;

   assign pready  = 1'b1;
   assign reg_idx = paddr[tpcs_pkg::ADDR_BITS-1:2];
   assign wr_en   = psel && penable && pwrite && pready;
   assign wr_val  = pwdata[CB-1:0];

   always_comb begin
      vertices_in = vertices_ff;
      if (wr_en) begin
         case (reg_idx)
            tpcs_pkg::REG_VERTEX_A_X: vertices_in.ax = wr_val;
            tpcs_pkg::REG_VERTEX_A_Y: vertices_in.ay = wr_val;
            tpcs_pkg::REG_VERTEX_B_X: vertices_in.bx = wr_val;
            tpcs_pkg::REG_VERTEX_B_Y: vertices_in.by = wr_val;
            tpcs_pkg::REG_VERTEX_C_X: vertices_in.cx = wr_val;
            tpcs_pkg::REG_VERTEX_C_Y: vertices_in.cy = wr_val;
            default: vertices_in = vertices_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertices_ff <= '0;
      end else begin
         vertices_ff <= vertices_in;
      end
   end

   always_comb begin
      case (reg_idx)
         tpcs_pkg::REG_VERTEX_A_X: rd_val = vertices_ff.ax;
         tpcs_pkg::REG_VERTEX_A_Y: rd_val = vertices_ff.ay;
         tpcs_pkg::REG_VERTEX_B_X: rd_val = vertices_ff.bx;
         tpcs_pkg::REG_VERTEX_B_Y: rd_val = vertices_ff.by;
         tpcs_pkg::REG_VERTEX_C_X: rd_val = vertices_ff.cx;
         tpcs_pkg::REG_VERTEX_C_Y: rd_val = vertices_ff.cy;
         default: rd_val = '0;
      endcase
   end

   assign prdata = tpcs_pkg::DATA_BITS'(rd_val);

   // pixel path: area front end, then the divider chain
   assign busy = 1'b0;

   logic                   chain_valid [tpcs_pkg::DIV_STEPS+1];
   tpcs_pkg::div_word_type chain_word  [tpcs_pkg::DIV_STEPS+1];

   tpcs_area_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_x      (req_pixel_x),
      .in_y      (req_pixel_y),
      .vertices  (vertices_ff),
      .out_valid (chain_valid[0]),
      .out_word  (chain_word[0])
   );

   for (genvar i = 0; i < tpcs_pkg::DIV_STEPS; i++) begin : g_cell
      tpcs_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .prev_valid (chain_valid[i]),
         .prev_word  (chain_word[i]),
         .valid      (chain_valid[i+1]),
         .word       (chain_word[i+1])
      );
   end

   tpcs_pkg::div_word_type last_word;

   assign last_word      = chain_word[tpcs_pkg::DIV_STEPS];
   assign rsp_valid      = chain_valid[tpcs_pkg::DIV_STEPS];
   assign rsp_out_x      = last_word.x;
   assign rsp_out_y      = last_word.y;
   assign rsp_covered    = last_word.covered;
   // quotient is meaningless off the triangle or with a zero divisor
   assign rsp_gray       = last_word.covered ? last_word.quo : '0;
   assign rsp_degenerate = last_word.degenerate;

   // assertions
   `TPCS_ASSERT_IMPL(a_cov_excl_degen, rsp_valid, !(rsp_covered && rsp_degenerate))
   `TPCS_ASSERT_IMPL(a_gray_off_tri, rsp_valid && !rsp_covered, rsp_gray == '0)
   `TPCS_ASSERT_IMPL(a_latency, start && !busy, ##(tpcs_pkg::LATENCY) rsp_valid)
   `TPCS_ASSERT_IMPL(a_no_stray_rsp, rsp_valid, $past(start && !busy, tpcs_pkg::LATENCY))
   `TPCS_ASSERT_NEXT(a_wr_ax, wr_en && (reg_idx == tpcs_pkg::REG_VERTEX_A_X), vertices_ff.ax == $past(wr_val))

endmodule

// ===== src/tpcs_area_front.sv =====
// ---------------------------------------------------------------------------
// tpcs_area_front
// three-stage edge area pipeline: products, edge sums, coverage and numerator
// ---------------------------------------------------------------------------
module tpcs_area_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  tpcs_pkg::coord_type      in_x,
   input  tpcs_pkg::coord_type      in_y,
   input  tpcs_pkg::vertex_set_type vertices,
   output logic                     out_valid,
   output tpcs_pkg::div_word_type   out_word
);

   localparam int AB = tpcs_pkg::AREA_BITS;
   localparam int NB = tpcs_pkg::NUM_BITS;

   function automatic logic [tpcs_pkg::MAG_BITS-1:0] mag_of(input logic signed [AB-1:0] v);
      logic signed [AB-1:0] n;
      n = -v;
      mag_of = v[AB-1] ? tpcs_pkg::MAG_BITS'(n) : tpcs_pkg::MAG_BITS'(v);
   endfunction

   tpcs_pkg::coord_type vx [3];
   tpcs_pkg::coord_type vy [3];

   assign vx[0] = vertices.ax;
   assign vy[0] = vertices.ay;
   assign vx[1] = vertices.bx;
   assign vy[1] = vertices.by;
   assign vx[2] = vertices.cx;
   assign vy[2] = vertices.cy;

   // stage 1: edge e runs from vertex q to vertex r, area linear in the pixel
   logic signed [tpcs_pkg::PROD_BITS-1:0] p1_in [3];
   logic signed [tpcs_pkg::PROD_BITS-1:0] p2_in [3];
   logic [tpcs_pkg::CONST_BITS-1:0]       c1_in [3];
   logic [tpcs_pkg::CONST_BITS-1:0]       c2_in [3];
   logic signed [tpcs_pkg::PROD_BITS-1:0] p1_ff [3];
   logic signed [tpcs_pkg::PROD_BITS-1:0] p2_ff [3];
   logic [tpcs_pkg::CONST_BITS-1:0]       c1_ff [3];
   logic [tpcs_pkg::CONST_BITS-1:0]       c2_ff [3];

   logic signed [tpcs_pkg::DIFF_BITS-1:0] px_s;
   logic signed [tpcs_pkg::DIFF_BITS-1:0] py_s;

   assign px_s = $signed({1'b0, in_x});
   assign py_s = $signed({1'b0, in_y});

   for (genvar e = 0; e < 3; e++) begin : g_edge
      localparam int Q = (e + 1) % 3;
      localparam int R = (e + 2) % 3;
      logic signed [tpcs_pkg::DIFF_BITS-1:0] kx;
      logic signed [tpcs_pkg::DIFF_BITS-1:0] ky;
      assign kx = $signed({1'b0, vy[Q]}) - $signed({1'b0, vy[R]});
      assign ky = $signed({1'b0, vx[R]}) - $signed({1'b0, vx[Q]});
      assign p1_in[e] = tpcs_pkg::PROD_BITS'(kx) * tpcs_pkg::PROD_BITS'(px_s);
      assign p2_in[e] = tpcs_pkg::PROD_BITS'(ky) * tpcs_pkg::PROD_BITS'(py_s);
      assign c1_in[e] = tpcs_pkg::CONST_BITS'(vy[R]) * tpcs_pkg::CONST_BITS'(vx[Q]);
      assign c2_in[e] = tpcs_pkg::CONST_BITS'(vy[Q]) * tpcs_pkg::CONST_BITS'(vx[R]);
   end

   logic                valid1_ff;
   tpcs_pkg::coord_type x1_ff;
   tpcs_pkg::coord_type y1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff <= in_x;
      y1_ff <= in_y;
      for (int e = 0; e < 3; e++) begin
         p1_ff[e] <= p1_in[e];
         p2_ff[e] <= p2_in[e];
         c1_ff[e] <= c1_in[e];
         c2_ff[e] <= c2_in[e];
      end
   end

   // stage 2: signed edge areas
   logic signed [AB-1:0] area_in [3];
   logic signed [AB-1:0] area_ff [3];
   logic                 valid2_ff;
   tpcs_pkg::coord_type  x2_ff;
   tpcs_pkg::coord_type  y2_ff;

   always_comb begin
      for (int e = 0; e < 3; e++) begin
         area_in[e] = AB'(p1_ff[e]) + AB'(p2_ff[e])
                    + $signed(AB'(c1_ff[e])) - $signed(AB'(c2_ff[e]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      x2_ff <= x1_ff;
      y2_ff <= y1_ff;
      for (int e = 0; e < 3; e++) begin
         area_ff[e] <= area_in[e];
      end
   end

   // stage 3: total area is the sum of the sub-areas
   logic signed [AB-1:0]          total;
   logic                          all_nonneg;
   logic                          all_nonpos;
   logic                          degen;
   logic                          cov;
   logic [tpcs_pkg::MAG_BITS-1:0] mag_a;
   logic [tpcs_pkg::MAG_BITS-1:0] mag_b;
   logic [tpcs_pkg::MAG_BITS-1:0] mag_g;
   logic [tpcs_pkg::MAG_BITS-1:0] mag_t;
   logic [NB-1:0]                 num;
   tpcs_pkg::div_word_type        word_in;
   tpcs_pkg::div_word_type        word_ff;
   logic                          valid3_ff;

   always_comb begin
      total      = area_ff[0] + area_ff[1] + area_ff[2];
      all_nonneg = !area_ff[0][AB-1] && !area_ff[1][AB-1] && !area_ff[2][AB-1];
      all_nonpos = (area_ff[0][AB-1] || (area_ff[0] == '0))
                && (area_ff[1][AB-1] || (area_ff[1] == '0))
                && (area_ff[2][AB-1] || (area_ff[2] == '0));
      degen      = (total == '0);
      cov        = !degen && (all_nonneg || all_nonpos);
      mag_a      = mag_of(area_ff[0]);
      mag_b      = mag_of(area_ff[1]);
      mag_g      = mag_of(area_ff[2]);
      mag_t      = mag_of(total);
      num        = NB'(tpcs_pkg::W_A) * NB'(mag_a)
                 + NB'(tpcs_pkg::W_B) * NB'(mag_b)
                 + NB'(tpcs_pkg::W_G) * NB'(mag_g);
      word_in.x          = x2_ff;
      word_in.y          = y2_ff;
      word_in.covered    = cov;
      word_in.degenerate = degen;
      word_in.rem        = cov ? num : '0;
      // divisor lined up with the top quotient bit
      word_in.dsh        = NB'(mag_t) << (tpcs_pkg::GRAY_BITS - 1);
      word_in.quo        = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else begin
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_valid = valid3_ff;
   assign out_word  = word_ff;

endmodule

// ===== src/tpcs_div_cell.sv =====
// ---------------------------------------------------------------------------
// tpcs_div_cell
// one restoring division step: settles one quotient bit and hands on the word
// ---------------------------------------------------------------------------
module tpcs_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   prev_valid,
   input  tpcs_pkg::div_word_type prev_word,
   output logic                   valid,
   output tpcs_pkg::div_word_type word
);

   logic                   valid_ff;
   tpcs_pkg::div_word_type word_in;
   tpcs_pkg::div_word_type word_ff;

   always_comb begin
      word_in = prev_word;
      if (prev_word.rem >= prev_word.dsh) begin
         word_in.rem = prev_word.rem - prev_word.dsh;
         word_in.quo = {prev_word.quo[tpcs_pkg::GRAY_BITS-2:0], 1'b1};
      end else begin
         word_in.quo = {prev_word.quo[tpcs_pkg::GRAY_BITS-2:0], 1'b0};
      end
      word_in.dsh = prev_word.dsh >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign valid = valid_ff;
   assign word  = word_ff;

endmodule

// ===== sim/triangle_shader_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// triangle shader checker
// follows vertex register writes and pixel words, predicts coverage, gray and
// degenerate flag for each pixel, compares every result word in order and checks register reads
// ---------------------------------------------------------------------------
module triangle_shader_checker
   import tpcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  coord_type             req_pixel_x,
   input  coord_type             req_pixel_y,
   input  logic                  rsp_valid,
   input  coord_type             rsp_out_x,
   input  coord_type             rsp_out_y,
   input  logic                  rsp_covered,
   input  logic [GRAY_BITS-1:0]  rsp_gray,
   input  logic                  rsp_degenerate,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_BITS-1:0]  paddr,
   input  logic [DATA_BITS-1:0]  pwdata,
   input  logic [DATA_BITS-1:0]  prdata,
   input  logic                  pready,
   output int                    mismatch_count,
   output int                    words_in_flight,
   output int                    words_checked,
   output int                    covered_seen,
   output int                    degenerate_seen,
   output int                    reads_checked
);

   localparam int PRINT_CAP = 100;

   typedef struct packed {
      coord_type             x;
      coord_type             y;
      logic                  covered;
      logic [GRAY_BITS-1:0]  gray;
      logic                  degenerate;
   } shade_word_type;

   vertex_set_type  triangle;
   shade_word_type  shade_q[$];
   int              n_bad     = 0;
   int              n_checked = 0;
   int              n_covered = 0;
   int              n_degen   = 0;
   int              n_reads   = 0;

   assign mismatch_count  = n_bad;
   assign words_checked   = n_checked;
   assign covered_seen    = n_covered;
   assign degenerate_seen = n_degen;
   assign reads_checked   = n_reads;

   task automatic report_mismatch(input string field, input longint got, input longint want);
      n_bad++;
      if (n_bad <= PRINT_CAP)
         $display("%0t ns mismatch on %s: got %0d, expected %0d", $time, field, got, want);
   endtask

   // twice the signed shoelace area of (p, q, r)
   function automatic longint doubled_area(input longint px, input longint py,
                                           input longint qx, input longint qy,
                                           input longint rx, input longint ry);
      return (qy - py) * (qx + px) + (ry - qy) * (rx + qx) + (py - ry) * (px + rx);
   endfunction

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // zero counts as being on either side
   function automatic bit same_side(input longint v, input longint total);
      return (v == 0) || ((v > 0) == (total > 0));
   endfunction

   function automatic shade_word_type shade_pixel(input vertex_set_type tv,
                                                 input coord_type x, input coord_type y);
      longint total;
      longint ea;
      longint eb;
      longint eg;
      longint quot;
      shade_word_type w;
      w   = '0;
      w.x = x;
      w.y = y;
      total = doubled_area(tv.ax, tv.ay, tv.bx, tv.by, tv.cx, tv.cy);
      if (total == 0) begin
         w.degenerate = 1'b1;
      end else begin
         ea = doubled_area(x, y, tv.bx, tv.by, tv.cx, tv.cy);
         eb = doubled_area(x, y, tv.cx, tv.cy, tv.ax, tv.ay);
         eg = doubled_area(x, y, tv.ax, tv.ay, tv.bx, tv.by);
         if (same_side(ea, total) && same_side(eb, total) && same_side(eg, total)) begin
            quot = (W_A * magnitude(ea) + W_B * magnitude(eb) + W_G * magnitude(eg))
                   / magnitude(total);
            w.covered = 1'b1;
            w.gray    = (quot > 255) ? '1 : GRAY_BITS'(quot);
         end
      end
      return w;
   endfunction

   function automatic coord_type vertex_register(input vertex_set_type tv,
                                                input logic [REG_IDX_BITS-1:0] idx);
      case (idx)
         REG_VERTEX_A_X: return tv.ax;
         REG_VERTEX_A_Y: return tv.ay;
         REG_VERTEX_B_X: return tv.bx;
         REG_VERTEX_B_Y: return tv.by;
         REG_VERTEX_C_X: return tv.cx;
         REG_VERTEX_C_Y: return tv.cy;
         default:        return '0;
      endcase
   endfunction

   always @(posedge clock) begin : monitor
      shade_word_type              want;
      logic [REG_IDX_BITS-1:0]     idx;
      logic [DATA_BITS-1:0]        read_want;
      if (reset) begin
         triangle = '0;
         shade_q.delete();
      end else begin
         if (rsp_valid) begin
            if (shade_q.size() == 0) begin
               report_mismatch("result word with none expected, x", rsp_out_x, -1);
            end else begin
               want = shade_q.pop_front();
               n_checked++;
               n_covered += want.covered;
               n_degen   += want.degenerate;
               if (rsp_out_x !== want.x)
                  report_mismatch("out_x", rsp_out_x, want.x);
               if (rsp_out_y !== want.y)
                  report_mismatch("out_y", rsp_out_y, want.y);
               if (rsp_covered !== want.covered)
                  report_mismatch("covered", rsp_covered, want.covered);
               if (rsp_gray !== want.gray)
                  report_mismatch("gray", rsp_gray, want.gray);
               if (rsp_degenerate !== want.degenerate)
                  report_mismatch("degenerate", rsp_degenerate, want.degenerate);
            end
         end

         // pixel uses the vertices as they were before any write at this edge
         if (start && !busy)
            shade_q.push_back(shade_pixel(triangle, req_pixel_x, req_pixel_y));

         if (psel && penable && pready) begin
            idx = paddr[ADDR_BITS-1:2];
            if (pwrite) begin
               case (idx)
                  REG_VERTEX_A_X: triangle.ax = pwdata[COORD_BITS-1:0];
                  REG_VERTEX_A_Y: triangle.ay = pwdata[COORD_BITS-1:0];
                  REG_VERTEX_B_X: triangle.bx = pwdata[COORD_BITS-1:0];
                  REG_VERTEX_B_Y: triangle.by = pwdata[COORD_BITS-1:0];
                  REG_VERTEX_C_X: triangle.cx = pwdata[COORD_BITS-1:0];
                  REG_VERTEX_C_Y: triangle.cy = pwdata[COORD_BITS-1:0];
                  default: ;
               endcase
            end else if (idx <= REG_VERTEX_C_Y) begin
               read_want = DATA_BITS'(vertex_register(triangle, idx));
               n_reads++;
               if (prdata !== read_want)
                  report_mismatch("register read", prdata, read_want);
            end
         end
      end
      words_in_flight <= shade_q.size();
   end

endmodule

// ===== sim/tb_triangle_pixel_coverage_shader_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_triangle_pixel_coverage_shader_top
// loads triangles through the register port and streams pixel words: edge
// and corner cases first, then random triangles and pixels with sender gaps
// ---------------------------------------------------------------------------
module tb_triangle_pixel_coverage_shader_top;
   import tpcs_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_WORDS    = 71;
   localparam int DRAIN_CYCLES   = LATENCY + 8;

   // addresses past the vertex list, writes there are dropped
   localparam logic [REG_IDX_BITS-1:0] REG_SPARE_6 = REG_IDX_BITS'(6);
   localparam logic [REG_IDX_BITS-1:0] REG_SPARE_7 = REG_IDX_BITS'(7);
   localparam coord_type COORD_MAX = '1;

   typedef enum int {
      SHAPE_ANY,
      SHAPE_TINY,
      SHAPE_CORNERS,
      SHAPE_FLAT,
      SHAPE_WIDE
   } shape_kind_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  start       = 1'b0;
   logic                  busy;
   coord_type             req_pixel_x = '0;
   coord_type             req_pixel_y = '0;
   logic                  rsp_valid;
   coord_type             rsp_out_x;
   coord_type             rsp_out_y;
   logic                  rsp_covered;
   logic [GRAY_BITS-1:0]  rsp_gray;
   logic                  rsp_degenerate;
   logic                  psel        = 1'b0;
   logic                  penable     = 1'b0;
   logic                  pwrite      = 1'b0;
   logic [ADDR_BITS-1:0]  paddr       = '0;
   logic [DATA_BITS-1:0]  pwdata      = '0;
   logic [DATA_BITS-1:0]  prdata;
   logic                  pready;

   int mismatch_count;
   int words_in_flight;
   int words_checked;
   int covered_seen;
   int degenerate_seen;
   int reads_checked;

   int sender_idle_pct = 0;
   int triangles_set   = 0;
   int pixels_sent     = 0;
   int idle_cycles     = 0;
   vertex_set_type shape = '0;

   always #5 clock = ~clock;

   triangle_pixel_coverage_shader_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .rsp_valid      (rsp_valid),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_covered    (rsp_covered),
      .rsp_gray       (rsp_gray),
      .rsp_degenerate (rsp_degenerate),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   triangle_shader_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .rsp_valid       (rsp_valid),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_covered     (rsp_covered),
      .rsp_gray        (rsp_gray),
      .rsp_degenerate  (rsp_degenerate),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .mismatch_count  (mismatch_count),
      .words_in_flight (words_in_flight),
      .words_checked   (words_checked),
      .covered_seen    (covered_seen),
      .degenerate_seen (degenerate_seen),
      .reads_checked   (reads_checked)
   );

   // watchdog: any handshake on any port restarts the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("** triangle_pixel_coverage_shader_top: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_pixel(input coord_type x, input coord_type y);
      start       <= 1'b1;
      req_pixel_x <= x;
      req_pixel_y <= y;
      do @(posedge clock); while (busy);
      pixels_sent++;
   endtask

   task automatic sender_gap();
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   // psel stays high across back-to-back transfers; csr_release ends a batch
   task automatic csr_access(input logic [REG_IDX_BITS-1:0] idx, input logic is_write,
                             input coord_type value);
      logic [DATA_BITS-1:0] word;
      word = ($urandom_range(3) == 0) ? DATA_BITS'($urandom) : '0;
      word[COORD_BITS-1:0] = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {idx, 2'b00};
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic csr_release();
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic load_triangle(input coord_type ax, input coord_type ay,
                                input coord_type bx, input coord_type by,
                                input coord_type cx, input coord_type cy);
      csr_access(REG_VERTEX_A_X, 1'b1, ax);
      csr_access(REG_VERTEX_A_Y, 1'b1, ay);
      csr_access(REG_VERTEX_B_X, 1'b1, bx);
      csr_access(REG_VERTEX_B_Y, 1'b1, by);
      csr_access(REG_VERTEX_C_X, 1'b1, cx);
      csr_access(REG_VERTEX_C_Y, 1'b1, cy);
      shape = '{ax, ay, bx, by, cx, cy};
      triangles_set++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (words_in_flight != 0) @(posedge clock);
   endtask

   function automatic coord_type pick_between(input coord_type p, input coord_type q,
                                             input coord_type r);
      coord_type lo;
      coord_type hi;
      lo = p;
      hi = p;
      if (q < lo) lo = q;
      if (r < lo) lo = r;
      if (q > hi) hi = q;
      if (r > hi) hi = r;
      return coord_type'($urandom_range(hi, lo));
   endfunction

   function automatic coord_type pick_edge_coord();
      return $urandom_range(1) ? COORD_MAX : coord_type'(0);
   endfunction

   task automatic random_triangle(input shape_kind_type kind);
      coord_type v[6];
      int ox;
      int oy;
      foreach (v[i]) v[i] = coord_type'($urandom);
      case (kind)
         SHAPE_TINY: begin
            ox = $urandom_range(1023 - 40);
            oy = $urandom_range(1023 - 40);
            for (int i = 0; i < 6; i += 2) begin
               v[i]     = coord_type'(ox + $urandom_range(40));
               v[i + 1] = coord_type'(oy + $urandom_range(40));
            end
         end
         SHAPE_CORNERS: begin
            foreach (v[i]) v[i] = pick_edge_coord();
         end
         SHAPE_FLAT: begin
            // repeated vertex or all three on one vertical line
            case ($urandom_range(2))
               0: begin v[4] = v[0]; v[5] = v[1]; end
               1: begin v[2] = v[4]; v[3] = v[5]; end
               default: begin v[2] = v[0]; v[4] = v[0]; end
            endcase
         end
         SHAPE_WIDE: begin
            v[0] = coord_type'($urandom_range(100));
            v[1] = coord_type'($urandom_range(100));
            v[2] = coord_type'($urandom_range(1023, 900));
            v[5] = coord_type'($urandom_range(1023, 900));
         end
         default: ;
      endcase
      load_triangle(v[0], v[1], v[2], v[3], v[4], v[5]);
   endtask

   initial begin
      coord_type x;
      coord_type y;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // vertices all zero after reset
      send_pixel('0, '0);
      send_pixel(COORD_MAX, COORD_MAX);
      wait_drained();

      // full-size counter-clockwise triangle: vertices, edges, inside, outside
      load_triangle('0, '0, COORD_MAX, '0, '0, COORD_MAX);
      csr_release();
      send_pixel('0, '0);
      send_pixel(COORD_MAX, '0);
      send_pixel('0, COORD_MAX);
      send_pixel(10'd511, 10'd511);
      send_pixel(10'd512, 10'd511);
      send_pixel(COORD_MAX, COORD_MAX);
      send_pixel(10'd300, 10'd100);
      send_pixel('0, 10'd500);
      wait_drained();

      // clockwise winding, negative total area
      load_triangle(COORD_MAX, COORD_MAX, COORD_MAX, '0, '0, COORD_MAX);
      csr_access(REG_SPARE_6, 1'b1, COORD_MAX);
      csr_access(REG_SPARE_7, 1'b1, 10'h155);
      for (int i = REG_VERTEX_A_X; i <= REG_VERTEX_C_Y; i++)
         csr_access(REG_IDX_BITS'(i), 1'b0, '0);
      csr_release();
      send_pixel(COORD_MAX, COORD_MAX);
      send_pixel(10'd700, 10'd700);
      send_pixel(10'd512, 10'd511);
      send_pixel(10'd100, 10'd100);
      send_pixel(10'd1000, 10'd900);
      wait_drained();

      // three distinct collinear vertices
      load_triangle(10'd10, 10'd10, 10'd500, 10'd500, 10'd1000, 10'd1000);
      csr_release();
      send_pixel(10'd500, 10'd500);
      send_pixel(10'd10, 10'd10);
      wait_drained();

      // smallest non-degenerate triangle
      load_triangle(10'd5, 10'd5, 10'd6, 10'd5, 10'd5, 10'd6);
      csr_release();
      send_pixel(10'd5, 10'd5);
      send_pixel(10'd6, 10'd6);
      send_pixel(10'd6, 10'd5);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            1: sender_idle_pct = 57;
            3: sender_idle_pct = 19;
            default: sender_idle_pct = 0;
         endcase
         random_triangle(shape_kind_type'(phase % 5));
         if ($urandom_range(2) == 0)
            csr_access($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, 1'b1,
                       coord_type'($urandom));
         csr_access(REG_IDX_BITS'($urandom_range(REG_VERTEX_C_Y)), 1'b0, '0);
         csr_release();
         for (int n = 0; n < PHASE_WORDS; n++) begin
            case ($urandom_range(7))
               0: begin
                  x = coord_type'($urandom);
                  y = coord_type'($urandom);
               end
               1: begin
                  x = pick_edge_coord();
                  y = pick_edge_coord();
               end
               default: begin
                  x = pick_between(shape.ax, shape.bx, shape.cx);
                  y = pick_between(shape.ay, shape.by, shape.cy);
               end
            endcase
            send_pixel(x, y);
            sender_gap();
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run: %0d pixel words over %0d triangle settings, %0d results checked",
               pixels_sent, triangles_set, words_checked);
      $display("run: %0d covered, %0d on zero-area triangles, %0d register reads compared",
               covered_seen, degenerate_seen, reads_checked);
      if (mismatch_count == 0 && words_in_flight == 0)
         $display("** triangle_pixel_coverage_shader_top: PASSED **");
      else
         $display("** triangle_pixel_coverage_shader_top: FAILED **");
      $finish;
   end

endmodule
